>>> design/itrs_pkg.sv
// Shared types, constants and helpers for the integer-to-radix-string block.
// No dependencies; used by every module of the block.
package itrs_pkg;

  // Width of the number field on the input stream
  localparam int VALUE_IN_W     = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Text room limit and radix limits
  localparam int MAX_ROOM  = 33;
  localparam int ROOM_W    = 6;
  localparam int RADIX_W   = 6;
  localparam int MIN_RADIX = 2;
  localparam int MAX_RADIX = 36;
  localparam int RADIX_RST = 10;
  localparam int ROOM_RST  = 33;

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Division steps taken per clock
  localparam int DIV_STEPS = 8;

  // Character codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_TEN   = 7'd10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS = 2'd1;

  // Stream widths
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ROOM_W-1:0]  max_chars;
  } cfg_t;

  // Map a digit value (below 36) to its ASCII character
  function automatic logic [6:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [6:0] dx;
    dx = {1'b0, d};
    if (dx < CHAR_TEN) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A + dx - CHAR_TEN;
    end
  endfunction

endpackage

>>> design/itrs_front.sv
// Front end: accepts input transactions, works out sign and magnitude,
// and holds them in a short queue for the converter. Depends on itrs_pkg.
module itrs_front #(
  parameter int VALUE_BITS = itrs_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [itrs_pkg::VALUE_IN_W-1:0]   s_tdata,
  input  logic                              s_tuser,
  output logic                              q_valid,
  input  logic                              q_pop,
  output logic [VALUE_BITS-1:0]             q_mag,
  output logic                              q_neg
);

  localparam int QD  = itrs_pkg::QUEUE_DEPTH;
  localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW  = $clog2(QD + 1);

  logic [VALUE_BITS-1:0] v;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push;

  logic [VALUE_BITS:0]   qmem [QD];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [CW-1:0]         count;

  // Fit the input number to the working width
  generate
    if (VALUE_BITS <= itrs_pkg::VALUE_IN_W) begin : g_trunc
      assign v = s_tdata[VALUE_BITS-1:0];
    end else begin : g_ext
      assign v = {{(VALUE_BITS - itrs_pkg::VALUE_IN_W){1'b0}}, s_tdata};
    end
  endgenerate

  // Classify: negative only when read as signed with the top bit set
  assign neg = s_tuser & v[VALUE_BITS-1];
  assign mag = neg ? (~v + 1'b1) : v;

  assign s_tready = (count != CW'(QD));
  assign push     = s_tvalid & s_tready;
  assign q_valid  = (count != '0);
  assign q_mag    = qmem[rd_ptr][VALUE_BITS-1:0];
  assign q_neg    = qmem[rd_ptr][VALUE_BITS];

  // Store classified items
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= {neg, mag};
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
        count <= count + 1'b1;
      end else if (!push && q_pop && q_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/itrs_back.sv
// Back end: extracts digits by repeated division of the magnitude by the
// radix, stacks them and streams the text out most significant first.
// Depends on itrs_pkg.
module itrs_back #(
  parameter int VALUE_BITS = itrs_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  itrs_pkg::cfg_t                     cfg,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  logic [VALUE_BITS-1:0]              q_mag,
  input  logic                               q_neg,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [itrs_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);

  localparam int DS     = itrs_pkg::DIV_STEPS;
  localparam int DIV_W  = ((VALUE_BITS + DS - 1) / DS) * DS;
  localparam int CYCLES = DIV_W / DS;
  localparam int STEP_W = (CYCLES > 1) ? $clog2(CYCLES) : 1;
  localparam int RW     = itrs_pkg::RADIX_W;
  localparam int NW     = itrs_pkg::ROOM_W;
  localparam int ROOM   = itrs_pkg::MAX_ROOM;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [RW-1:0]         base;
  logic [NW-1:0]         room;
  logic [NW-1:0]         nd;
  logic                  ddrop;
  logic                  sdrop;
  logic                  sign_pend;
  logic [DIV_W-1:0]      dq;
  logic [RW-1:0]         rem;
  logic [STEP_W-1:0]     step;
  logic [6:0]            stack [ROOM];

  logic [DIV_W-1:0]      dq_next;
  logic [RW-1:0]         rem_next;
  logic                  push;
  logic [6:0]            push_char;
  logic                  pop;
  logic                  out_free;
  logic                  emit;
  logic [RW-1:0]         base_clamped;
  logic [NW-1:0]         room_clamped;
  logic                  fits;

  // Clamp configuration to the legal radix and room
  always_comb begin
    if (cfg.radix < RW'(itrs_pkg::MIN_RADIX)) begin
      base_clamped = RW'(itrs_pkg::MIN_RADIX);
    end else if (cfg.radix > RW'(itrs_pkg::MAX_RADIX)) begin
      base_clamped = RW'(itrs_pkg::MAX_RADIX);
    end else begin
      base_clamped = cfg.radix;
    end
    room_clamped = (cfg.max_chars > NW'(ROOM)) ? NW'(ROOM) : cfg.max_chars;
  end

  // Restoring division, several quotient bits per clock
  always_comb begin
    logic [RW:0] r;
    dq_next  = dq;
    rem_next = rem;
    for (int j = 0; j < DS; j++) begin
      r = {rem_next, dq_next[DIV_W-1]};
      dq_next = {dq_next[DIV_W-2:0], (r >= {1'b0, base})};
      if (r >= {1'b0, base}) begin
        rem_next = RW'(r - {1'b0, base});
      end else begin
        rem_next = r[RW-1:0];
      end
    end
  end

  assign fits     = (nd < room);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_EMIT) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // Stack push: a zero value's '0', or a finished digit
  always_comb begin
    push      = 1'b0;
    push_char = itrs_pkg::digit_char(rem_next);
    if (state == ST_CHECK && mag == '0 && nd == '0 && room != '0) begin
      push      = 1'b1;
      push_char = itrs_pkg::CHAR_ZERO;
    end else if (state == ST_DIV && step == STEP_W'(CYCLES - 1)) begin
      push = 1'b1;
    end
  end

  assign pop = (state == ST_EMIT) && out_free && !sign_pend && (nd != '0);

  // Digit stack: newest (most significant) digit sits at the top
  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= push_char;
      for (int i = 1; i < ROOM; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < ROOM - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  // Conversion sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nd        <= '0;
      ddrop     <= 1'b0;
      sdrop     <= 1'b0;
      sign_pend <= 1'b0;
      step      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // Load the output register on a new character, clear it once taken
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            mag   <= q_mag;
            neg   <= q_neg;
            base  <= base_clamped;
            room  <= room_clamped;
            nd    <= '0;
            ddrop <= 1'b0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (mag == '0 && nd == '0) begin
            // Zero value: a single '0' if there is room
            if (room != '0) begin
              nd <= nd + 1'b1;
            end else begin
              ddrop <= 1'b1;
            end
            sign_pend <= 1'b0;
            sdrop     <= 1'b0;
            state     <= ST_EMIT;
          end else if (mag != '0 && fits) begin
            dq    <= DIV_W'(mag);
            rem   <= '0;
            step  <= '0;
            state <= ST_DIV;
          end else begin
            ddrop     <= (mag != '0);
            sign_pend <= neg && fits;
            sdrop     <= neg && !fits;
            state     <= ST_EMIT;
          end
        end
        ST_DIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == STEP_W'(CYCLES - 1)) begin
            mag   <= dq_next[VALUE_BITS-1:0];
            nd    <= nd + 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (!sign_pend && nd == '0) begin
              // Empty text
              m_tdata <= itrs_pkg::OUT_DATA_W'({sdrop, ddrop, 7'd0});
              m_tuser <= 1'b0;
              m_tlast <= 1'b1;
              state   <= ST_IDLE;
            end else if (sign_pend) begin
              sign_pend <= 1'b0;
              m_tdata   <= itrs_pkg::OUT_DATA_W'({sdrop && nd == '0, ddrop && nd == '0,
                                                  itrs_pkg::CHAR_MINUS});
              m_tuser   <= 1'b1;
              m_tlast   <= (nd == '0);
              if (nd == '0) begin
                state <= ST_IDLE;
              end
            end else begin
              nd      <= nd - 1'b1;
              m_tdata <= itrs_pkg::OUT_DATA_W'({sdrop && nd == NW'(1),
                                                ddrop && nd == NW'(1), stack[0]});
              m_tuser <= 1'b1;
              m_tlast <= (nd == NW'(1));
              if (nd == NW'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/integer_to_radix_string.sv
// Top level of the integer-to-radix-string converter: configuration
// registers, front end with input queue, and digit back end.
// Depends on itrs_pkg, itrs_front and itrs_back.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tdata: value; tuser: treat_as_signed
//  m_*       out        m_tvalid / m_tready  tdata: char_code, digits_dropped,
//                                            sign_dropped; tuser: char_valid; tlast
//  cfg_*     in         cfg_we               cfg_index, cfg_data
//
// The back end converts one item at a time: the shared divider, retiring 8
// quotient bits per clock, produces each digit, and the characters are then
// sent as output transactions.
// Two classified items can wait in the queue while one converts.
// Reset (rst, synchronous) empties the queue and output; radix returns to 10
// and room to 33. A stalled output holds its transaction and stops the
// converter at its next character.
module integer_to_radix_string #(
  parameter int VALUE_BITS = itrs_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [itrs_pkg::VALUE_IN_W-1:0]     s_tdata,   // [31:0] value
  input  logic                                s_tuser,   // [0] treat_as_signed
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [itrs_pkg::OUT_DATA_W-1:0]     m_tdata,   // [6:0] char_code,
                                                         // [7] digits_dropped,
                                                         // [8] sign_dropped
  output logic                                m_tuser,   // [0] char_valid
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [itrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itrs_pkg::RADIX_W-1:0]        cfg_data
);

  itrs_pkg::cfg_t        cfg;
  logic                  q_valid;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] q_mag;
  logic                  q_neg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix     <= itrs_pkg::RADIX_W'(itrs_pkg::RADIX_RST);
      cfg.max_chars <= itrs_pkg::ROOM_W'(itrs_pkg::ROOM_RST);
    end else if (cfg_we) begin
      if (cfg_index == itrs_pkg::REG_RADIX) begin
        cfg.radix <= cfg_data;
      end else if (cfg_index == itrs_pkg::REG_MAX_CHARS) begin
        cfg.max_chars <= itrs_pkg::ROOM_W'(cfg_data);
      end
    end
  end

  itrs_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_mag    (q_mag),
    .q_neg    (q_neg)
  );

  itrs_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_mag    (q_mag),
    .q_neg    (q_neg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> design/itrs_checker.sv
// Port-level checks for the integer-to-radix-string converter, bound to
// the top level. Depends on itrs_pkg.
module itrs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [itrs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // Empty text is a single, final transaction
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[6:0] == 7'd0)
    else $error("empty text not final");

  // Drop flags appear only on the final character
  a_flags_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[8:7] == 2'b00)
    else $error("drop flag before final character");

  // Every character is a minus, a decimal digit or a lower-case letter
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[6:0] == itrs_pkg::CHAR_MINUS) ||
      (m_tdata[6:0] >= 7'h30 && m_tdata[6:0] <= 7'h39) ||
      (m_tdata[6:0] >= 7'h61 && m_tdata[6:0] <= 7'h7a))
    else $error("character outside the digit set");

endmodule

bind integer_to_radix_string itrs_checker u_itrs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> tb/itrs_text_checker.sv
`timescale 1ns / 100ps
// Checker for the integer-to-radix-string block: tracks register writes,
// predicts the text of each input transaction and compares every output one.
// Depends on itrs_pkg.
module itrs_text_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [itrs_pkg::VALUE_IN_W-1:0] s_tdata,   // [31:0] value
  input  logic                            s_tuser,   // [0] treat_as_signed
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [itrs_pkg::OUT_DATA_W-1:0] m_tdata,   // [6:0] char_code,
                                                     // [7] digits_dropped,
                                                     // [8] sign_dropped
  input  logic                            m_tuser,   // [0] char_valid
  input  logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [itrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itrs_pkg::RADIX_W-1:0]    cfg_data,
  output int                              fail_count,
  output int                              chars_pending
);

  typedef struct packed {
    logic [6:0] code;
    logic       valid;
    logic       last;
    logic       dig_drop;
    logic       sgn_drop;
  } text_char_t;

  text_char_t                   text_q[$];
  logic [itrs_pkg::RADIX_W-1:0] radix_reg;
  logic [itrs_pkg::ROOM_W-1:0]  room_reg;

  // Build the expected characters of one conversion, most significant first
  function automatic void predict_text(input logic [31:0] value, input logic as_signed);
    logic [6:0] digit_buf [itrs_pkg::MAX_ROOM];
    logic [31:0] mag;
    logic [6:0]  code;
    int          base;
    int          room;
    int          ndig;
    int          dval;
    logic        is_neg;
    logic        dig_drop;
    logic        sgn_drop;
    logic        with_sign;
    logic        last;
    base = int'(radix_reg);
    if (base < itrs_pkg::MIN_RADIX) base = itrs_pkg::MIN_RADIX;
    if (base > itrs_pkg::MAX_RADIX) base = itrs_pkg::MAX_RADIX;
    room = int'(room_reg);
    if (room > itrs_pkg::MAX_ROOM) room = itrs_pkg::MAX_ROOM;
    // two's complement negation leaves the most negative value at 2^31
    is_neg = as_signed & value[31];
    mag = is_neg ? (~value + 32'd1) : value;
    ndig = 0;
    dig_drop = 1'b0;
    sgn_drop = 1'b0;
    with_sign = 1'b0;
    if (mag == 32'd0) begin
      if (room > 0) begin
        digit_buf[0] = itrs_pkg::CHAR_ZERO;
        ndig = 1;
      end else begin
        dig_drop = 1'b1;
      end
    end else begin
      // fill the room from the least significant digit up
      while (mag != 32'd0 && ndig < room) begin
        dval = int'(mag % 32'(base));
        code = 7'(dval);
        digit_buf[ndig] = (dval < 10) ? itrs_pkg::CHAR_ZERO + code
                                      : itrs_pkg::CHAR_A + code - 7'd10;
        mag = mag / 32'(base);
        ndig++;
      end
      if (mag != 32'd0) dig_drop = 1'b1;
    end
    if (is_neg) begin
      if (ndig < room) with_sign = 1'b1;
      else sgn_drop = 1'b1;
    end
    // empty text still gives one item carrying the flags
    if (ndig == 0 && !with_sign) begin
      text_q.push_back('{7'd0, 1'b0, 1'b1, dig_drop, sgn_drop});
      return;
    end
    if (with_sign) begin
      last = (ndig == 0);
      text_q.push_back('{itrs_pkg::CHAR_MINUS, 1'b1, last,
                         last & dig_drop, last & sgn_drop});
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      last = (i == 0);
      text_q.push_back('{digit_buf[i], 1'b1, last, last & dig_drop, last & sgn_drop});
    end
  endfunction

  // Compare output transactions, then track writes and input transactions
  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (rst) begin
      radix_reg = itrs_pkg::RADIX_W'(itrs_pkg::RADIX_RST);
      room_reg = itrs_pkg::ROOM_W'(itrs_pkg::ROOM_RST);
      text_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[6:0], m_tuser, m_tlast, m_tdata[7], m_tdata[8]};
        if (text_q.size() == 0) begin
          $display("%0t: unexpected char: actual code=%h valid=%b last=%b dd=%b sd=%b",
                   $time, got.code, got.valid, got.last, got.dig_drop, got.sgn_drop);
          fail_count++;
        end else begin
          want = text_q.pop_front();
          if (got !== want) begin
            $display("%0t: char mismatch: expected code=%h valid=%b last=%b dd=%b sd=%b",
                     $time, want.code, want.valid, want.last, want.dig_drop, want.sgn_drop);
            $display("%0t:                  actual code=%h valid=%b last=%b dd=%b sd=%b",
                     $time, got.code, got.valid, got.last, got.dig_drop, got.sgn_drop);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == itrs_pkg::REG_RADIX) radix_reg = cfg_data;
        else if (cfg_index == itrs_pkg::REG_MAX_CHARS) room_reg = cfg_data;
      end
      if (s_tvalid && s_tready) predict_text(s_tdata, s_tuser);
    end
    chars_pending = text_q.size();
  end

endmodule

>>> tb/tb_integer_to_radix_string.sv
`timescale 1ns / 100ps
// Top of the integer-to-radix-string testbench: clock, reset, stimulus and
// verdict. Depends on itrs_pkg, integer_to_radix_string and itrs_text_checker.
module tb_integer_to_radix_string;

  // Register indexes the block does not implement
  localparam logic [itrs_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [itrs_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_SESSION = 30;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [itrs_pkg::VALUE_IN_W-1:0]  s_tdata;   // [31:0] value
  logic                             s_tuser;   // [0] treat_as_signed
  logic                             m_tvalid;
  logic                             m_tready;
  logic [itrs_pkg::OUT_DATA_W-1:0]  m_tdata;   // [6:0] char_code, [7] digits_dropped,
                                               // [8] sign_dropped
  logic                             m_tuser;   // [0] char_valid
  logic                             m_tlast;
  logic                             cfg_we;
  logic [itrs_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [itrs_pkg::RADIX_W-1:0]     cfg_data;
  int                               fail_count;
  int                               chars_pending;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  bit hold_taken;
  int hold_left;

  integer_to_radix_string u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  itrs_text_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .chars_pending(chars_pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Drive output ready: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one input transaction, idling first at random, and wait for acceptance
  task automatic send_value(input logic [31:0] value, input logic as_signed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= as_signed;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected char has arrived
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [itrs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [itrs_pkg::RADIX_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix of zero, small, small negative, extreme, single-bit and full-range values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'($urandom_range(40));
      2: return -32'($urandom_range(40, 1));
      3: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h8000_0001;
        endcase
      end
      4: return 32'd1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [itrs_pkg::RADIX_W-1:0] pick_radix();
    case ($urandom_range(7))
      0: return 6'(itrs_pkg::MIN_RADIX);
      1: return 6'(itrs_pkg::MAX_RADIX);
      2: return 6'($urandom_range(1));           // clamped up to 2
      3: return 6'($urandom_range(63, 37));      // clamped down to 36
      default: return 6'($urandom_range(itrs_pkg::MAX_RADIX, itrs_pkg::MIN_RADIX));
    endcase
  endfunction

  function automatic logic [itrs_pkg::ROOM_W-1:0] pick_room();
    case ($urandom_range(7))
      0: return 6'($urandom_range(2));
      1: return 6'(itrs_pkg::MAX_ROOM);
      2: return 6'($urandom_range(63, 34));      // clamped to 33
      default: return 6'($urandom_range(itrs_pkg::MAX_ROOM));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, radix 10 with full room
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_value(32'd0, 1'b0);
    send_value(32'd0, 1'b1);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'hffff_ffff, 1'b1);
    send_value(32'h8000_0000, 1'b1);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7fff_ffff, 1'b1);
    send_value(32'd12345, 1'b1);
    drain();

    // Radix below two acts as binary: longest texts
    write_reg(itrs_pkg::REG_RADIX, 6'd0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b1);
    drain();

    // Radix above 36 acts as 36
    write_reg(itrs_pkg::REG_RADIX, 6'd63);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'd35, 1'b0);
    drain();

    // No room: empty text with flags
    write_reg(itrs_pkg::REG_RADIX, 6'd16);
    write_reg(itrs_pkg::REG_MAX_CHARS, 6'd0);
    send_value(32'd0, 1'b0);
    send_value(32'hffff_fffb, 1'b1);
    drain();

    // Room of one: sign dropped, digits dropped
    write_reg(itrs_pkg::REG_MAX_CHARS, 6'd1);
    send_value(32'hffff_fffb, 1'b1);
    send_value(32'd255, 1'b0);
    drain();

    // Room of two: sign just fits
    write_reg(itrs_pkg::REG_MAX_CHARS, 6'd2);
    send_value(32'hffff_fff1, 1'b1);
    drain();

    // Room above the limit, radix one; spare indexes must not change anything
    write_reg(itrs_pkg::REG_MAX_CHARS, 6'd63);
    write_reg(itrs_pkg::REG_RADIX, 6'd1);
    write_reg(REG_SPARE_2, 6'd5);
    write_reg(REG_SPARE_3, 6'd0);
    send_value(32'h8000_0000, 1'b1);
    send_value(32'd100, 1'b0);
    drain();

    // Random: three idle settings, several register settings in each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int sess = 0; sess < 4; sess++) begin
        write_reg(itrs_pkg::REG_RADIX, pick_radix());
        write_reg(itrs_pkg::REG_MAX_CHARS, pick_room());
        if ($urandom_range(3) == 0)
          write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 6'($urandom()));
        // long receiver hold-off while the sender keeps offering
        if (phase == 2 && sess == 0) hold_req = 1'b1;
        for (int n = 0; n < ITEMS_PER_SESSION; n++)
          send_value(pick_value(), 1'($urandom_range(1)));
        drain();
      end
    end

    repeat (200) @(negedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
